[rtl/fcfb_pkg.sv]
// ----------------------------------------------------------------------------
// fcfb_pkg
// Shared types and constants of the formant correction filter bank.
// ----------------------------------------------------------------------------
package fcfb_pkg;

  localparam int DEF_NUM_BANDS    = 14;
  localparam int DEF_MAX_CHANNELS = 8;

  localparam int IDX_W      = 5;   // source band index, holds up to 32 bands
  localparam int CH_W       = 4;   // channel index, holds up to 16 channels
  localparam int DIVIDEND_W = 44;
  localparam int QUOT_W     = 24;

  localparam int ONE_Q24 = 16777216;
  localparam int ONE_Q20 = 1048576;
  localparam logic [23:0] ENV_FLOOR = 24'd84;
  localparam logic [23:0] GAIN_MIN  = 24'd104858;
  localparam logic [23:0] GAIN_MAX  = 24'd12582912;

  typedef enum logic [1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_COEF   = 2'd1,
    CMD_MAP    = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    REG_ENABLE       = 3'd0,
    REG_NUM_CHANNELS = 3'd1,
    REG_ATTACK       = 3'd2,
    REG_RELEASE      = 3'd3,
    REG_GAIN_SMOOTH  = 3'd4
  } reg_e;

  typedef struct packed {
    logic signed [15:0] x1;
    logic signed [15:0] x2;
    logic signed [31:0] y1;
    logic signed [31:0] y2;
    logic        [23:0] env;
    logic        [23:0] gain;
  } state_t;

  typedef struct packed {
    logic signed [31:0] b0;
    logic signed [31:0] a1;
    logic signed [31:0] a2;
  } coef_t;

  typedef struct packed {
    logic [IDX_W-1:0] lo;
    logic [IDX_W-1:0] hi;
    logic [15:0]      frac;
  } map_t;

  typedef struct packed {
    logic [23:0] attack;
    logic [23:0] release_c;
    logic [23:0] gain_smooth;
  } cfg_t;

  typedef struct packed {
    logic               start;
    logic [CH_W-1:0]    ch;
    logic signed [15:0] x;
  } core_req_t;

  typedef struct packed {
    logic idle;
    logic done;
  } core_stat_t;

endpackage

[rtl/fcfb_state_mem.sv]
// ----------------------------------------------------------------------------
// fcfb_state_mem
// Per channel and band state memory, one write and one registered read port.
// ----------------------------------------------------------------------------
module fcfb_state_mem #(
  parameter int DEPTH = fcfb_pkg::DEF_NUM_BANDS * fcfb_pkg::DEF_MAX_CHANNELS,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [AW-1:0]        waddr,
  input  fcfb_pkg::state_t     wdata,
  input  logic                 re,
  input  logic [AW-1:0]        raddr,
  output fcfb_pkg::state_t     rdata
);
  import fcfb_pkg::*;

  state_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/fcfb_div.sv]
// ----------------------------------------------------------------------------
// fcfb_div
// Restoring divider, one quotient bit per cycle. The caller guarantees that
// the quotient fits in QUOT_W bits.
// ----------------------------------------------------------------------------
module fcfb_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [fcfb_pkg::DIVIDEND_W-1:0]   dividend,
  input  logic [fcfb_pkg::QUOT_W-1:0]       divisor,
  output logic [fcfb_pkg::QUOT_W-1:0]       quotient,
  output logic                              done
);
  import fcfb_pkg::*;

  localparam int CNT_W = $clog2(QUOT_W + 1);

  logic [QUOT_W-1:0] rem;
  logic [QUOT_W-1:0] shifter;
  logic [QUOT_W-1:0] den;
  logic [CNT_W-1:0]  cnt;
  logic              busy;
  logic [QUOT_W:0]   trial;
  logic              fits;

  assign trial = {rem, shifter[QUOT_W-1]};
  assign fits  = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        cnt      <= '0;
        rem      <= QUOT_W'(dividend[DIVIDEND_W-1:QUOT_W]);
        shifter  <= dividend[QUOT_W-1:0];
        den      <= divisor;
        quotient <= '0;
      end else if (busy) begin
        rem      <= fits ? QUOT_W'(trial - {1'b0, den}) : trial[QUOT_W-1:0];
        shifter  <= {shifter[QUOT_W-2:0], 1'b0};
        quotient <= {quotient[QUOT_W-2:0], fits};
        cnt      <= cnt + 1'b1;
        if (cnt == CNT_W'(QUOT_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[rtl/fcfb_core.sv]
// ----------------------------------------------------------------------------
// fcfb_core
// Band sequencer: runs the filters and envelopes, then the gains, over the
// state memory with one shared multiplier and the divider.
// ----------------------------------------------------------------------------
module fcfb_core #(
  parameter int NUM_BANDS    = fcfb_pkg::DEF_NUM_BANDS,
  parameter int MAX_CHANNELS = fcfb_pkg::DEF_MAX_CHANNELS,
  parameter int BW           = $clog2(NUM_BANDS)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  fcfb_pkg::core_req_t       req,
  input  fcfb_pkg::cfg_t            cfg,
  output logic [BW-1:0]             band_sel,
  input  fcfb_pkg::coef_t           coef_rd,
  input  fcfb_pkg::map_t            map_rd,
  output fcfb_pkg::core_stat_t      stat,
  output logic signed [15:0]        result
);
  import fcfb_pkg::*;

  localparam int DEPTH = MAX_CHANNELS * NUM_BANDS;
  localparam int AW    = $clog2(DEPTH);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE,
    S_P1_READ, S_P1_MUL0, S_P1_MUL1, S_P1_MUL2, S_P1_SAT, S_P1_MAG,
    S_P1_ENV0, S_P1_ENV1, S_P1_WRITE,
    S_P2_RDLO, S_P2_RDHI, S_P2_RDK, S_P2_DES, S_P2_DIV,
    S_P2_GAIN0, S_P2_GAIN1, S_P2_GAIN2, S_P2_CORR0, S_P2_CORR1,
    S_FIN
  } core_state_t;

  core_state_t        state;
  logic [BW-1:0]      band;
  logic [AW-1:0]      base;
  logic [AW-1:0]      clr_addr;
  logic signed [15:0] x;
  logic signed [39:0] acc;
  logic signed [31:0] y;
  logic [23:0]        mag;
  logic [24:0]        cf;
  logic signed [65:0] tmp;
  logic [23:0]        el;
  logic               ovf;
  logic [23:0]        tgt;
  logic [23:0]        gain_r;
  logic signed [63:0] corr;
  logic               done;

  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [65:0] prod;

  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  state_t             mem_wdata;
  logic               mem_re;
  logic [AW-1:0]      mem_raddr;
  state_t             rdata;

  logic [AW-1:0]      kaddr;
  logic signed [16:0] xdiff;
  logic signed [39:0] ysum;
  logic [32:0]        yabs;
  logic [25:0]        mag_wide;
  logic [23:0]        mag_c;
  logic signed [65:0] mac_sum;
  logic signed [24:0] env_diff;
  logic signed [26:0] desired;
  logic [23:0]        des_pos;
  logic [23:0]        den;
  logic               div_start;
  logic [QUOT_W-1:0]  quot;
  logic               div_done;
  logic signed [63:0] out_sum;
  logic [23:0]        q_clamped;

  assign band_sel = band;
  assign kaddr    = base + AW'(band);
  assign xdiff    = 17'(x) - 17'(rdata.x2);
  assign ysum     = acc - 40'(prod >>> 30);
  assign yabs     = y[31] ? 33'(-33'(y)) : 33'(y);
  assign mag_wide = yabs[32:7];
  assign mag_c    = (mag_wide > 26'hFFFFFF) ? 24'hFFFFFF : mag_wide[23:0];
  assign mac_sum  = tmp + prod;
  assign env_diff = $signed({1'b0, rdata.env}) - $signed({1'b0, el});
  assign desired  = $signed({3'b000, el}) + 27'(prod >>> 16);
  assign des_pos  = desired[26] ? 24'd0 : desired[23:0];
  assign den      = (rdata.env < ENV_FLOOR) ? ENV_FLOOR : rdata.env;
  assign div_start = (state == S_P2_DES);
  assign out_sum  = 64'(x) + (corr >>> 35);
  assign q_clamped = (quot < GAIN_MIN) ? GAIN_MIN : ((quot > GAIN_MAX) ? GAIN_MAX : quot);

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_P1_MUL0: begin
        mul_a = 33'(coef_rd.b0);
        mul_b = 33'(xdiff);
      end
      S_P1_MUL1: begin
        mul_a = 33'(coef_rd.a1);
        mul_b = 33'(rdata.y1);
      end
      S_P1_MUL2: begin
        mul_a = 33'(coef_rd.a2);
        mul_b = 33'(rdata.y2);
      end
      S_P1_ENV0: begin
        mul_a = {8'b0, cf};
        mul_b = {9'b0, rdata.env};
      end
      S_P1_ENV1: begin
        mul_a = {8'b0, 25'(ONE_Q24) - cf};
        mul_b = {9'b0, mag};
      end
      S_P2_RDK: begin
        mul_a = {17'b0, map_rd.frac};
        mul_b = 33'(env_diff);
      end
      S_P2_GAIN0: begin
        mul_a = {9'b0, cfg.gain_smooth};
        mul_b = {9'b0, rdata.gain};
      end
      S_P2_GAIN1: begin
        mul_a = {8'b0, 25'(ONE_Q24) - {1'b0, cfg.gain_smooth}};
        mul_b = {9'b0, tgt};
      end
      S_P2_CORR0: begin
        mul_a = 33'(rdata.y1);
        mul_b = $signed({9'b0, gain_r}) - 33'(ONE_Q20);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // memory port select
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = kaddr;
    mem_wdata = rdata;
    mem_re    = 1'b0;
    mem_raddr = kaddr;
    case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = '{x1: '0, x2: '0, y1: '0, y2: '0, env: '0, gain: 24'(ONE_Q20)};
      end
      S_P1_READ: mem_re = 1'b1;
      S_P1_WRITE: begin
        mem_we    = 1'b1;
        mem_wdata = '{x1: x, x2: rdata.x1, y1: y, y2: rdata.y1,
                      env: mac_sum[47:24], gain: rdata.gain};
      end
      S_P2_RDLO: begin
        mem_re    = 1'b1;
        mem_raddr = base + AW'(BW'(map_rd.lo));
      end
      S_P2_RDHI: begin
        mem_re    = 1'b1;
        mem_raddr = base + AW'(BW'(map_rd.hi));
      end
      S_P2_RDK: mem_re = 1'b1;
      S_P2_GAIN2: begin
        mem_we         = 1'b1;
        mem_wdata.gain = mac_sum[47:24];
      end
      default: begin
        mem_we = 1'b0;
        mem_re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      band     <= '0;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req.start) begin
            base  <= AW'(req.ch * NUM_BANDS);
            x     <= req.x;
            band  <= '0;
            corr  <= '0;
            state <= S_P1_READ;
          end
        end
        S_P1_READ: state <= S_P1_MUL0;
        S_P1_MUL0: state <= S_P1_MUL1;
        S_P1_MUL1: begin
          acc   <= 40'(prod >>> 15);
          state <= S_P1_MUL2;
        end
        S_P1_MUL2: begin
          acc   <= acc - 40'(prod >>> 30);
          state <= S_P1_SAT;
        end
        S_P1_SAT: begin
          if (ysum > 40'sd2147483647) begin
            y <= 32'sh7FFFFFFF;
          end else if (ysum < -40'sd2147483648) begin
            y <= 32'sh80000000;
          end else begin
            y <= ysum[31:0];
          end
          state <= S_P1_MAG;
        end
        S_P1_MAG: begin
          mag   <= mag_c;
          cf    <= {1'b0, (mag_c > rdata.env) ? cfg.attack : cfg.release_c};
          state <= S_P1_ENV0;
        end
        S_P1_ENV0: state <= S_P1_ENV1;
        S_P1_ENV1: begin
          tmp   <= prod;
          state <= S_P1_WRITE;
        end
        S_P1_WRITE: begin
          if (band == BW'(NUM_BANDS - 1)) begin
            band  <= '0;
            state <= S_P2_RDLO;
          end else begin
            band  <= band + 1'b1;
            state <= S_P1_READ;
          end
        end
        S_P2_RDLO: state <= S_P2_RDHI;
        S_P2_RDHI: begin
          el    <= rdata.env;
          state <= S_P2_RDK;
        end
        S_P2_RDK: state <= S_P2_DES;
        S_P2_DES: begin
          // quotient would not fit in QUOT_W bits
          ovf   <= {4'b0, des_pos} >= {den, 4'b0};
          state <= S_P2_DIV;
        end
        S_P2_DIV: begin
          if (div_done) begin
            tgt   <= ovf ? GAIN_MAX : q_clamped;
            state <= S_P2_GAIN0;
          end
        end
        S_P2_GAIN0: state <= S_P2_GAIN1;
        S_P2_GAIN1: begin
          tmp   <= prod;
          state <= S_P2_GAIN2;
        end
        S_P2_GAIN2: begin
          gain_r <= mac_sum[47:24];
          state  <= S_P2_CORR0;
        end
        S_P2_CORR0: state <= S_P2_CORR1;
        S_P2_CORR1: begin
          corr <= corr + 64'(prod);
          if (band == BW'(NUM_BANDS - 1)) begin
            state <= S_FIN;
          end else begin
            band  <= band + 1'b1;
            state <= S_P2_RDLO;
          end
        end
        S_FIN: begin
          if (out_sum > 64'sd32767) begin
            result <= 16'sh7FFF;
          end else if (out_sum < -64'sd32768) begin
            result <= 16'sh8000;
          end else begin
            result <= out_sum[15:0];
          end
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign stat.idle = (state == S_IDLE);
  assign stat.done = done;

  fcfb_state_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (rdata)
  );

  fcfb_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({des_pos, 20'b0}),
    .divisor  (den),
    .quotient (quot),
    .done     (div_done)
  );

endmodule

[rtl/formant_correction_filter_bank_unit.sv]
// ----------------------------------------------------------------------------
// formant_correction_filter_bank_unit
// Per channel band-pass bank with envelope driven gain correction.
// ----------------------------------------------------------------------------
// Input requests carry a cmd. cmd 1 and cmd 2 load one band's filter
// coefficients or source mapping and give no result; load all bands
// before sending samples. cmd 0 is an audio sample of the current
// channel; it gives one output request with the corrected sample and its
// channel. Registers are to be written on the cfg port only while the
// block is idle; the block itself does not enforce this. Per band, the
// filter and envelope take nine steps of the shared multiplier over the
// state memory; the gain takes four steps, a wait on the one-bit-per-cycle
// division and five more steps. One sample is in work at a time. With
// enable low the sample bypasses the core: it is held as the pending
// result, then moved to the output register once that is free.
// After reset the state memory is cleared, one entry a cycle, all
// MAX_CHANNELS * NUM_BANDS entries (112), with in_stall high.
// A finished result waits in the output register while out_stall is high;
// the next sample may be taken meanwhile, and its result is held inside.
// ----------------------------------------------------------------------------
module formant_correction_filter_bank_unit #(
  parameter int NUM_BANDS    = fcfb_pkg::DEF_NUM_BANDS,
  parameter int MAX_CHANNELS = fcfb_pkg::DEF_MAX_CHANNELS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         cmd,
  input  logic signed [15:0] sample_in,
  input  logic [3:0]         band_index,
  input  logic signed [31:0] coef_b0,
  input  logic signed [31:0] coef_a1,
  input  logic signed [31:0] coef_a2,
  input  logic [3:0]         src_low,
  input  logic [3:0]         src_high,
  input  logic [15:0]        src_fraction,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] sample_out,
  output logic [2:0]         channel_out,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_data
);
  import fcfb_pkg::*;

  localparam int BW  = $clog2(NUM_BANDS);
  localparam int CIW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  logic               enable;
  logic [3:0]         num_channels;
  cfg_t               cfg;
  logic [CIW-1:0]     chidx;
  logic               busy;
  logic               res_pend;
  logic signed [15:0] res_sample;
  logic [2:0]         res_ch;
  core_req_t          core_req;
  core_stat_t         core_stat;
  logic signed [15:0] core_result;
  logic [BW-1:0]      band_sel;
  coef_t              coef_tab [NUM_BANDS];
  map_t               map_tab [NUM_BANDS];

  logic               in_take;
  logic               band_ok;
  logic [4:0]         nch_eff;
  logic [CIW-1:0]     ch_cur;
  logic               out_free;

  assign in_stall = busy | ~core_stat.idle;
  assign in_take  = in_valid & ~in_stall;
  assign band_ok  = 32'(band_index) < 32'(NUM_BANDS);
  assign out_free = ~out_valid | ~out_stall;

  always_comb begin
    if (num_channels == 4'd0) begin
      nch_eff = 5'd1;
    end else if (5'(num_channels) > 5'(MAX_CHANNELS)) begin
      nch_eff = 5'(MAX_CHANNELS);
    end else begin
      nch_eff = 5'(num_channels);
    end
    ch_cur = (5'(chidx) >= nch_eff) ? '0 : chidx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enable       <= 1'b0;
      num_channels <= 4'd1;
      cfg          <= '{attack: 24'hFFFFFF, release_c: 24'hFFFFFF, gain_smooth: 24'hFFFFFF};
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ENABLE:       enable          <= cfg_data[0];
        REG_NUM_CHANNELS: num_channels    <= cfg_data[3:0];
        REG_ATTACK:       cfg.attack      <= cfg_data;
        REG_RELEASE:      cfg.release_c   <= cfg_data;
        REG_GAIN_SMOOTH:  cfg.gain_smooth <= cfg_data;
        default: ;
      endcase
    end
  end

  // band tables, loaded by command requests
  always_ff @(posedge clk) begin
    if (in_take && band_ok) begin
      if (cmd == CMD_COEF) begin
        coef_tab[BW'(band_index)] <= '{b0: coef_b0, a1: coef_a1, a2: coef_a2};
      end
      if (cmd == CMD_MAP) begin
        map_tab[BW'(band_index)] <= '{
          lo:   (32'(src_low) < 32'(NUM_BANDS)) ? IDX_W'(src_low) : IDX_W'(NUM_BANDS - 1),
          hi:   (32'(src_high) < 32'(NUM_BANDS)) ? IDX_W'(src_high) : IDX_W'(NUM_BANDS - 1),
          frac: src_fraction
        };
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chidx          <= '0;
      busy           <= 1'b0;
      res_pend       <= 1'b0;
      out_valid      <= 1'b0;
      core_req.start <= 1'b0;
    end else begin
      core_req.start <= 1'b0;
      if (in_take && cmd == CMD_SAMPLE) begin
        busy   <= 1'b1;
        res_ch <= 3'(ch_cur);
        chidx  <= (5'(ch_cur) + 5'd1 >= nch_eff) ? '0 : CIW'(ch_cur + 1'b1);
        if (enable) begin
          core_req.start <= 1'b1;
          core_req.ch    <= CH_W'(ch_cur);
          core_req.x     <= sample_in;
        end else begin
          res_pend   <= 1'b1;
          res_sample <= sample_in;
        end
      end
      if (core_stat.done) begin
        res_pend   <= 1'b1;
        res_sample <= core_result;
      end
      // move the held result out once the output register frees up
      if (res_pend && out_free) begin
        out_valid   <= 1'b1;
        sample_out  <= res_sample;
        channel_out <= res_ch;
        res_pend    <= 1'b0;
        busy        <= 1'b0;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  fcfb_core #(
    .NUM_BANDS    (NUM_BANDS),
    .MAX_CHANNELS (MAX_CHANNELS),
    .BW           (BW)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .req      (core_req),
    .cfg      (cfg),
    .band_sel (band_sel),
    .coef_rd  (coef_tab[band_sel]),
    .map_rd   (map_tab[band_sel]),
    .stat     (core_stat),
    .result   (core_result)
  );

  a_done_when_busy: assert property (@(posedge clk) disable iff (rst)
    core_stat.done |-> busy && !res_pend)
    else $error("core finished without a sample in work");

  a_start_when_idle: assert property (@(posedge clk) disable iff (rst)
    core_req.start |-> core_stat.idle)
    else $error("core started while not idle");

  a_result_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(busy) && !busy)
    else $error("output request without a finished sample");

endmodule

[test/fcfb_checker.sv]
// ----------------------------------------------------------------------------
// fcfb_checker
// Watches the request, result and register ports of the filter bank, keeps
// its own copy of the band state and tables, and compares each result with
// the oldest predicted sample.
// ----------------------------------------------------------------------------
module fcfb_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [1:0]         cmd,
  input  logic signed [15:0] sample_in,
  input  logic [3:0]         band_index,
  input  logic signed [31:0] coef_b0,
  input  logic signed [31:0] coef_a1,
  input  logic signed [31:0] coef_a2,
  input  logic [3:0]         src_low,
  input  logic [3:0]         src_high,
  input  logic [15:0]        src_fraction,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [15:0] sample_out,
  input  logic [2:0]         channel_out,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_data,
  output int                 errors,
  output int                 pending,
  output int                 checked
);
  import fcfb_pkg::*;

  localparam int NB    = DEF_NUM_BANDS;
  localparam int NCH   = DEF_MAX_CHANNELS;
  localparam int SLOTS = NB * NCH;
  localparam longint Q24 = 64'sd16777216;
  localparam longint Q20 = 64'sd1048576;

  typedef struct {
    logic signed [15:0] smp;
    logic [2:0]         ch;
  } out_sample_t;

  out_sample_t expected_samples[$];

  logic        en_r;
  logic [3:0]  nch_r;
  logic [23:0] attack_r, release_r, smooth_r;
  int unsigned chan;

  logic signed [15:0] xh1[SLOTS], xh2[SLOTS];
  logic signed [31:0] yh1[SLOTS], yh2[SLOTS];
  logic [23:0]        env[SLOTS], gain[SLOTS];
  logic signed [31:0] tb0[NB], ta1[NB], ta2[NB];
  logic [3:0]         mlo[NB], mhi[NB];
  logic [15:0]        mfr[NB];

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic logic signed [15:0] correct_sample(int unsigned ch, longint x);
    longint yb[NB];
    longint corr, y, mag, cf, el, eh, des, den, tgt, g;
    int k;
    corr = 0;
    for (int b = 0; b < NB; b++) begin
      k = ch * NB + b;
      y = ((longint'(tb0[b]) * (x - longint'(xh2[k]))) >>> 15)
        - ((longint'(ta1[b]) * longint'(yh1[k])) >>> 30)
        - ((longint'(ta2[b]) * longint'(yh2[k])) >>> 30);
      y = clip(y, -64'sd2147483648, 64'sd2147483647);
      xh2[k] = xh1[k];
      xh1[k] = x[15:0];
      yh2[k] = yh1[k];
      yh1[k] = y[31:0];
      yb[b] = y;
      mag = (y < 0 ? -y : y) >>> 7;
      if (mag > 64'sd16777215) mag = 64'sd16777215;
      cf = (mag > longint'(env[k])) ? longint'(attack_r) : longint'(release_r);
      env[k] = 24'((cf * longint'(env[k]) + (Q24 - cf) * mag) >>> 24);
    end
    g = longint'(smooth_r);
    for (int b = 0; b < NB; b++) begin
      k = ch * NB + b;
      el = longint'(env[ch * NB + mlo[b]]);
      eh = longint'(env[ch * NB + mhi[b]]);
      des = el + ((longint'(mfr[b]) * (eh - el)) >>> 16);
      if (des < 0) des = 0;
      den = env[k] < ENV_FLOOR ? longint'(ENV_FLOOR) : longint'(env[k]);
      tgt = (des <<< 20) / den;
      tgt = clip(tgt, longint'(GAIN_MIN), longint'(GAIN_MAX));
      gain[k] = 24'((g * longint'(gain[k]) + (Q24 - g) * tgt) >>> 24);
      corr += yb[b] * (longint'(gain[k]) - Q20);
    end
    return 16'(clip(x + (corr >>> 35), -64'sd32768, 64'sd32767));
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    int unsigned nch;
    out_sample_t r;
    if (rst) begin
      en_r = 1'b0;
      nch_r = 4'd1;
      attack_r = 24'hFFFFFF;
      release_r = 24'hFFFFFF;
      smooth_r = 24'hFFFFFF;
      chan = 0;
      for (int i = 0; i < SLOTS; i++) begin
        xh1[i] = '0; xh2[i] = '0; yh1[i] = '0; yh2[i] = '0;
        env[i] = '0; gain[i] = 24'(ONE_Q20);
      end
      for (int b = 0; b < NB; b++) begin
        tb0[b] = '0; ta1[b] = '0; ta2[b] = '0; mlo[b] = '0; mhi[b] = '0; mfr[b] = '0;
      end
      expected_samples.delete();
      errors = 0;
      checked = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_ENABLE:       en_r = cfg_data[0];
          REG_NUM_CHANNELS: nch_r = cfg_data[3:0];
          REG_ATTACK:       attack_r = cfg_data;
          REG_RELEASE:      release_r = cfg_data;
          REG_GAIN_SMOOTH:  smooth_r = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        if (cmd == CMD_COEF && band_index < NB) begin
          tb0[band_index] = coef_b0;
          ta1[band_index] = coef_a1;
          ta2[band_index] = coef_a2;
        end else if (cmd == CMD_MAP && band_index < NB) begin
          mlo[band_index] = src_low < NB ? src_low : 4'(NB - 1);
          mhi[band_index] = src_high < NB ? src_high : 4'(NB - 1);
          mfr[band_index] = src_fraction;
        end else if (cmd == CMD_SAMPLE) begin
          nch = nch_r == 0 ? 1 : (nch_r > NCH ? NCH : nch_r);
          if (chan >= nch) chan = 0;
          r.smp = en_r ? correct_sample(chan, longint'(sample_in)) : sample_in;
          r.ch = chan[2:0];
          expected_samples.push_back(r);
          chan++;
          if (chan >= nch) chan = 0;
        end
      end
      if (out_valid && !out_stall) begin
        if (expected_samples.size() == 0) begin
          report("unexpected result", sample_out, 0);
        end else begin
          r = expected_samples.pop_front();
          checked++;
          if (sample_out !== r.smp) report("sample_out", sample_out, r.smp);
          if (channel_out !== r.ch) report("channel_out", channel_out, r.ch);
        end
      end
    end
    pending = expected_samples.size();
  end

endmodule

[test/tb_formant_correction_filter_bank_unit.sv]
// ----------------------------------------------------------------------------
// tb_formant_correction_filter_bank_unit
// Drives table loads, samples and register settings into the filter bank
// with random gaps and output stalls; the checker predicts every sample.
// ----------------------------------------------------------------------------
module tb_formant_correction_filter_bank_unit;
  import fcfb_pkg::*;

  localparam logic [1:0] CMD_NONE = 2'd3;
  localparam int NB         = DEF_NUM_BANDS;
  localparam int PHASES     = 31;
  localparam int HOLD_LEN   = 3000;
  localparam int IDLE_LIMIT = 20000;

  typedef struct {
    logic [1:0]         cmd;
    logic signed [15:0] smp;
    logic [3:0]         band;
    logic signed [31:0] b0, a1, a2;
    logic [3:0]         lo, hi;
    logic [15:0]        frac;
  } request_t;

  logic clk, rst;
  logic in_valid, in_stall, out_valid, out_stall;
  logic [1:0] cmd;
  logic signed [15:0] sample_in, sample_out;
  logic [3:0] band_index, src_low, src_high;
  logic signed [31:0] coef_b0, coef_a1, coef_a2;
  logic [15:0] src_fraction;
  logic [2:0] channel_out;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [23:0] cfg_data;

  int errors, pending, checked;
  int sent;
  int idle_cycles;
  bit quiet, long_hold;

  formant_correction_filter_bank_unit i_dut (.*);

  fcfb_checker i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Stop if nothing moves on any port for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
      $display("FAILURE");
      $finish;
    end
  end

  // Receiver: random stall bursts, plus one long hold-off to fill the block.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_stall = 1'b1;
        repeat (HOLD_LEN) @(negedge clk);
        long_hold = 1'b0;
        out_stall = 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 10)) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'(int'($urandom_range(0, 511)) - 256);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic request_t random_request(logic [1:0] c);
    request_t r;
    r.cmd = c;
    r.smp = pick_sample();
    r.band = 4'($urandom);
    r.b0 = $urandom;
    r.a1 = $urandom;
    r.a2 = $urandom;
    r.lo = 4'($urandom);
    r.hi = 4'($urandom);
    r.frac = 16'($urandom);
    return r;
  endfunction

  // Hold the request until taken, then advance to the next falling edge.
  task automatic send(request_t r);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    cmd = r.cmd;
    sample_in = r.smp;
    band_index = r.band;
    coef_b0 = r.b0;
    coef_a1 = r.a1;
    coef_a2 = r.a2;
    src_low = r.lo;
    src_high = r.hi;
    src_fraction = r.frac;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(reg_e idx, logic [23:0] data);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  // Stable band-pass style coefficients, or raw bits that may saturate.
  task automatic load_tables(bit wild);
    request_t r;
    for (int b = 0; b < NB; b++) begin
      r = random_request(CMD_COEF);
      r.band = 4'(b);
      if (!wild) begin
        r.b0 = $urandom_range(0, 1 << 26);
        r.a2 = $urandom_range(858993459, 1063004405);
        r.a1 = int'($urandom_range(0, 1 << 30)) * ($urandom_range(0, 1) ? 1 : -1);
      end
      send(r);
      r = random_request(CMD_MAP);
      r.band = 4'(b);
      send(r);
    end
  endtask

  function automatic logic [23:0] pick_coef();
    case ($urandom_range(0, 4))
      0: return 24'h000000;
      1: return 24'hFFFFFF;
      2: return 24'($urandom_range(16000000, 16777215));
      default: return 24'($urandom);
    endcase
  endfunction

  initial begin
    request_t r;
    int n;
    bit en;
    rst = 1'b1;
    in_valid = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_ENABLE;
    cfg_data = '0;
    r = random_request(CMD_SAMPLE);
    cmd = CMD_SAMPLE;
    sample_in = '0;
    band_index = '0;
    coef_b0 = '0;
    coef_a1 = '0;
    coef_a2 = '0;
    src_low = '0;
    src_high = '0;
    src_fraction = '0;
    quiet = 1'b0;
    long_hold = 1'b0;
    sent = 0;
    repeat (11) @(negedge clk);
    rst = 1'b0;

    // Pass-through at reset settings, full-scale edges.
    r = random_request(CMD_SAMPLE);
    r.smp = 16'sh7FFF; send(r);
    r.smp = 16'sh8000; send(r);
    r.smp = 16'sh0000; send(r);
    r.smp = 16'shFFFF; send(r);
    // Ignored requests: unused command and out-of-range bands.
    send(random_request(CMD_NONE));
    r = random_request(CMD_COEF); r.band = 4'd14; send(r);
    r = random_request(CMD_MAP); r.band = 4'd15; send(r);
    load_tables(1'b0);
    // Source bands past the top saturate.
    r = random_request(CMD_MAP); r.band = 4'd0; r.lo = 4'd15; r.hi = 4'd14;
    r.frac = 16'hFFFF; send(r);
    drain();
    write_reg(REG_ENABLE, 24'd1);
    write_reg(REG_NUM_CHANNELS, 24'd2);
    write_reg(REG_ATTACK, 24'd0);
    write_reg(REG_RELEASE, 24'hFFFFFF);
    write_reg(REG_GAIN_SMOOTH, 24'd0);
    r = random_request(CMD_SAMPLE);
    r.smp = 16'sh7FFF; send(r);
    r.smp = 16'sh8000; send(r);
    r.smp = 16'sh7FFF; send(r);
    r.smp = 16'sh0000; send(r);

    for (int p = 0; p < PHASES; p++) begin
      drain();
      quiet = (p >= PHASES - 3);
      en = (p == 2) ? 1'b0 : ($urandom_range(0, 3) != 0);
      write_reg(REG_ENABLE, {23'($urandom), en});
      case (p % 4)
        0: write_reg(REG_NUM_CHANNELS, 24'd1);
        1: write_reg(REG_NUM_CHANNELS, 24'd8);
        default: write_reg(REG_NUM_CHANNELS, 24'($urandom_range(0, 15)));
      endcase
      write_reg(REG_ATTACK, pick_coef());
      write_reg(REG_RELEASE, pick_coef());
      write_reg(REG_GAIN_SMOOTH, pick_coef());
      if ($urandom_range(0, 2) == 0) load_tables($urandom_range(0, 3) == 0);
      // Fill the block while the receiver holds off.
      if (p == 2) long_hold = 1'b1;
      n = en ? $urandom_range(25, 40) : $urandom_range(40, 80);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 19) == 0) begin
          r = random_request($urandom_range(0, 1) ? CMD_NONE : CMD_COEF);
          if (r.cmd == CMD_COEF) r.band = 4'($urandom_range(14, 15));
        end else begin
          r = random_request(CMD_SAMPLE);
        end
        send(r);
      end
    end

    drain();
    $display("sent %0d requests over %0d register settings; %0d samples checked",
             sent, PHASES + 2, checked);
    if (errors == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[formant_correction_filter_bank_unit.f]
rtl/fcfb_pkg.sv
rtl/fcfb_state_mem.sv
rtl/fcfb_div.sv
rtl/fcfb_core.sv
rtl/formant_correction_filter_bank_unit.sv
test/fcfb_checker.sv
test/tb_formant_correction_filter_bank_unit.sv
